### sv/rhc_pkg.sv
`timescale 1ns / 1ps

package rhc_pkg;

  localparam int ChanW        = 8;
  localparam int PixW         = 3 * ChanW;
  localparam int FracW        = 16;
  localparam int HueW         = ChanW + 3;
  localparam int BitsPerStage = 2;
  localparam int DivStages    = FracW / BitsPerStage;

  localparam logic [FracW-1:0] SatMax = '1;

  typedef enum logic [2:0] {
    MaxRed   = 3'b001,
    MaxGreen = 3'b010,
    MaxBlue  = 3'b100
  } max_sel_t;

  typedef struct packed {
    logic [HueW-1:0]  hrem;
    logic [HueW-1:0]  hden;
    logic [FracW-1:0] hq;
    logic [ChanW-1:0] srem;
    logic [ChanW-1:0] sden;
    logic [FracW-1:0] sq;
    logic             sfull;
    logic             grey;
  } div_stage_t;

  // two restoring quotient bits for hue and saturation
  function automatic div_stage_t div_step(div_stage_t s);
    div_stage_t     o;
    logic [HueW:0]  ht;
    logic [ChanW:0] st;
    o = s;
    for (int i = 0; i < BitsPerStage; i++) begin
      ht = {o.hrem, 1'b0};
      st = {o.srem, 1'b0};
      if (ht >= {1'b0, o.hden}) begin
        o.hrem = HueW'(ht - {1'b0, o.hden});
        o.hq   = {o.hq[FracW-2:0], 1'b1};
      end else begin
        o.hrem = ht[HueW-1:0];
        o.hq   = {o.hq[FracW-2:0], 1'b0};
      end
      if (st >= {1'b0, o.sden}) begin
        o.srem = ChanW'(st - {1'b0, o.sden});
        o.sq   = {o.sq[FracW-2:0], 1'b1};
      end else begin
        o.srem = st[ChanW-1:0];
        o.sq   = {o.sq[FracW-2:0], 1'b0};
      end
    end
    return o;
  endfunction

endpackage

### sv/rgb_to_hsv_converter_unit.sv
// result registers follow pix1, the r2/d2 stage, dv[0] and the divider stages
// throughput: one pixel per clock while no result is stalled, set by the eight two-bit divider stages
// a stalled result freezes the whole pipeline, so pixel_stall follows result_stall
// reset clears every stage valid bit and result_valid; data registers keep no reset
`timescale 1ns / 1ps

module rgb_to_hsv_converter_unit (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        pixel_valid,
  output logic                        pixel_stall,
  input  logic [rhc_pkg::PixW-1:0]    pixel_rgb,
  output logic                        result_valid,
  input  logic                        result_stall,
  output logic [rhc_pkg::FracW-1:0]   hue,
  output logic [rhc_pkg::FracW-1:0]   saturation,
  output logic [rhc_pkg::ChanW-1:0]   brightness
);
  import rhc_pkg::*;

  logic                ce;
  logic                v1;
  logic                v2;
  logic                dvv [0:DivStages];
  logic [PixW-1:0]     pix1;
  logic [ChanW-1:0]    r1, g1, b1;
  logic [ChanW-1:0]    hi1, lo1;
  max_sel_t            sel1;
  logic [ChanW-1:0]    r2, g2, b2;
  logic [ChanW-1:0]    hi2, d2;
  max_sel_t            sel2;
  logic [HueW-1:0]     d6;
  logic [HueW-1:0]     n;
  div_stage_t          dv0_next;
  div_stage_t          dv [0:DivStages];
  div_stage_t          last;
  logic [FracW-1:0]    hue_next;
  logic [FracW-1:0]    saturation_next;

  assign pixel_stall = result_valid & result_stall;
  assign ce          = ~pixel_stall;

  // max, min and winning channel
  always_comb begin
    r1 = pix1[PixW-1 -: ChanW];
    g1 = pix1[2*ChanW-1 -: ChanW];
    b1 = pix1[ChanW-1:0];
    if (r1 >= g1 && r1 >= b1) begin
      sel1 = MaxRed;
      hi1  = r1;
    end else if (g1 >= b1) begin
      sel1 = MaxGreen;
      hi1  = g1;
    end else begin
      sel1 = MaxBlue;
      hi1  = b1;
    end
    lo1 = (r1 < g1) ? r1 : g1;
    lo1 = (lo1 < b1) ? lo1 : b1;
  end

  // hue numerator in sector units and divider setup
  always_comb begin
    d6 = HueW'({d2, 2'b00}) + HueW'({d2, 1'b0});
    case (sel2)
      MaxRed: begin
        if (g2 >= b2) n = HueW'(g2) - HueW'(b2);
        else          n = d6 - (HueW'(b2) - HueW'(g2));
      end
      MaxGreen: n = HueW'(b2) + HueW'({d2, 1'b0}) - HueW'(r2);
      MaxBlue:  n = HueW'(r2) + HueW'({d2, 2'b00}) - HueW'(g2);
      default:  n = '0;
    endcase
    dv0_next.hrem  = n;
    dv0_next.hden  = d6;
    dv0_next.hq    = '0;
    dv0_next.sfull = (d2 >= hi2);
    dv0_next.srem  = dv0_next.sfull ? '0 : d2;
    dv0_next.sden  = hi2;
    dv0_next.sq    = '0;
    dv0_next.grey  = (d2 == '0);
  end

  assign last = dv[DivStages];

  always_comb begin
    hue_next = last.grey ? '0 : last.hq;
    if (last.sden == '0)  saturation_next = '0;
    else if (last.sfull)  saturation_next = SatMax;
    else                  saturation_next = last.sq;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v1           <= 1'b0;
      v2           <= 1'b0;
      result_valid <= 1'b0;
      for (int k = 0; k <= DivStages; k++) dvv[k] <= 1'b0;
    end else if (ce) begin
      v1           <= pixel_valid;
      v2           <= v1;
      dvv[0]       <= v2;
      for (int k = 1; k <= DivStages; k++) dvv[k] <= dvv[k-1];
      result_valid <= dvv[DivStages];
    end
  end

  always_ff @(posedge clk) begin
    if (ce) begin
      pix1  <= pixel_rgb;
      r2    <= r1;
      g2    <= g1;
      b2    <= b1;
      hi2   <= hi1;
      d2    <= hi1 - lo1;
      sel2  <= sel1;
      dv[0] <= dv0_next;
      for (int k = 1; k <= DivStages; k++) dv[k] <= div_step(dv[k-1]);
      hue        <= hue_next;
      saturation <= saturation_next;
      brightness <= last.sden;
    end
  end

endmodule

### sv/rhc_checker.sv
`timescale 1ns / 1ps

module rhc_checker (
  input logic                      clk,
  input logic                      rst,
  input logic                      pixel_stall,
  input logic                      result_valid,
  input logic                      result_stall,
  input logic [rhc_pkg::FracW-1:0] hue,
  input logic [rhc_pkg::FracW-1:0] saturation,
  input logic [rhc_pkg::ChanW-1:0] brightness
);
  import rhc_pkg::*;

  // a stalled result stays offered
  a_hold_valid: assert property (@(posedge clk) disable iff (rst)
    result_valid && result_stall |=> result_valid)
    else $error("result dropped while stalled");

  // a stalled result keeps its payload
  a_hold_data: assert property (@(posedge clk) disable iff (rst)
    result_valid && result_stall |=> $stable(hue) && $stable(saturation)
      && $stable(brightness))
    else $error("result payload changed while stalled");

  // input backpressure only comes from a stalled result
  a_stall_src: assert property (@(posedge clk) disable iff (rst)
    pixel_stall |-> result_valid && result_stall)
    else $error("pixel stalled without a stalled result");

  // black gives zero hue and saturation
  a_black: assert property (@(posedge clk) disable iff (rst)
    result_valid && brightness == '0 |-> hue == '0 && saturation == '0)
    else $error("black pixel with nonzero hue or saturation");

  // zero saturation means grey, which has zero hue
  a_grey: assert property (@(posedge clk) disable iff (rst)
    result_valid && saturation == '0 |-> hue == '0)
    else $error("grey pixel with nonzero hue");

endmodule

bind rgb_to_hsv_converter_unit rhc_checker u_rhc_checker (.*);

### tb/tb_rgb_to_hsv_converter_unit.sv
`timescale 1ns / 1ps

module tb_rgb_to_hsv_converter_unit;
  import rhc_pkg::*;

  localparam int NumRandom = 1750;

  typedef struct packed {
    logic [FracW-1:0] hue;
    logic [FracW-1:0] sat;
    logic [ChanW-1:0] val;
  } hsv_t;

  logic             clk = 1'b0;
  logic             rst = 1'b1;
  logic             pixel_valid = 1'b0;
  logic             pixel_stall;
  logic [PixW-1:0]  pixel_rgb = '0;
  logic             result_valid;
  logic             result_stall = 1'b0;
  logic [FracW-1:0] hue;
  logic [FracW-1:0] saturation;
  logic [ChanW-1:0] brightness;

  logic [PixW-1:0] pixel_q[$];
  hsv_t            hsv_expected_q[$];
  hsv_t            exp_hsv;
  int              n_pixels = 0;
  int              pixels_sent = 0;
  int              results_seen = 0;
  int              gap_left = 0;
  int              stall_left = 0;
  int              next_left;
  int              errors = 0;

  rgb_to_hsv_converter_unit dut (
    .clk          (clk),
    .rst          (rst),
    .pixel_valid  (pixel_valid),
    .pixel_stall  (pixel_stall),
    .pixel_rgb    (pixel_rgb),
    .result_valid (result_valid),
    .result_stall (result_stall),
    .hue          (hue),
    .saturation   (saturation),
    .brightness   (brightness)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  function automatic hsv_t hsv_of_pixel(logic [PixW-1:0] px);
    hsv_t        o;
    int unsigned r, g, b, hi, lo, d, span, n, q;
    max_sel_t    sel;
    r = px[23:16];
    g = px[15:8];
    b = px[7:0];
    hi = r;
    sel = MaxRed;
    if (g > hi) begin
      hi = g;
      sel = MaxGreen;
    end
    if (b > hi) begin
      hi = b;
      sel = MaxBlue;
    end
    lo = r;
    if (g < lo) lo = g;
    if (b < lo) lo = b;
    d = hi - lo;
    o = '0;
    o.val = ChanW'(hi);
    if (hi != 0) begin
      q = (d * 65536) / hi;
      o.sat = (q > 65535) ? SatMax : FracW'(q);
      if (d != 0) begin
        span = 6 * d;
        case (sel)
          MaxRed:   n = (g >= b) ? (g - b) : (span - (b - g));
          MaxGreen: n = b + 2 * d - r;
          default:  n = r + 4 * d - g;
        endcase
        q = (n * 65536) / span;
        o.hue = (q > 65535) ? 16'hFFFF : FracW'(q);
      end
    end
    return o;
  endfunction

  // mixes fully random pixels with greys, ties, zero channels, tiny values and corner bytes
  function automatic logic [PixW-1:0] rand_pixel();
    logic [ChanW-1:0] c[3];
    logic [ChanW-1:0] m;
    int               k, j;
    k = $urandom_range(0, 9);
    for (int i = 0; i < 3; i++) c[i] = ChanW'($urandom);
    case (k)
      5: begin
        c[1] = c[0];
        c[2] = c[0];
      end
      6: begin
        m = ChanW'($urandom_range(1, 255));
        j = $urandom_range(0, 2);
        for (int i = 0; i < 3; i++) c[i] = (i == j) ? ChanW'($urandom_range(0, m)) : m;
      end
      7: c[$urandom_range(0, 2)] = '0;
      8: for (int i = 0; i < 3; i++) c[i] = ChanW'($urandom_range(0, 3));
      9: for (int i = 0; i < 3; i++) begin
        case ($urandom_range(0, 3))
          0:       c[i] = 8'h00;
          1:       c[i] = 8'h01;
          2:       c[i] = 8'hFE;
          default: c[i] = 8'hFF;
        endcase
      end
      default: ;
    endcase
    return {c[0], c[1], c[2]};
  endfunction

  // phases of heavy idling, no idling and sparse idling
  function automatic int idle_cycles(int idx);
    case ((idx / 150) % 3)
      0:       return $urandom_range(0, 13);
      1:       return 0;
      default: return ($urandom_range(0, 7) == 0) ? $urandom_range(0, 13) : 0;
    endcase
  endfunction

  always @(posedge clk) begin
    if (rst) begin
      pixel_valid <= 1'b0;
      pixel_rgb <= '0;
      gap_left = 0;
    end else if (!pixel_valid || !pixel_stall) begin
      if (pixel_valid) begin
        hsv_expected_q.push_back(hsv_of_pixel(pixel_rgb));
        pixels_sent++;
      end
      if (gap_left == 0 && pixel_q.size() > 0) begin
        pixel_rgb <= pixel_q.pop_front();
        pixel_valid <= 1'b1;
        gap_left = idle_cycles(pixels_sent);
      end else begin
        pixel_rgb <= PixW'($urandom);
        pixel_valid <= 1'b0;
        if (gap_left > 0) gap_left--;
      end
    end
  end

  always @(posedge clk) begin
    if (rst) begin
      result_stall <= 1'b0;
      stall_left = 0;
    end else begin
      next_left = stall_left;
      if (result_valid && !result_stall) begin
        if (hsv_expected_q.size() == 0) begin
          $display("%0t: unexpected transfer hue %h sat %h val %h", $time, hue, saturation,
                   brightness);
          errors++;
        end else begin
          exp_hsv = hsv_expected_q.pop_front();
          if (hue !== exp_hsv.hue) begin
            $display("%0t: hue expected %h actual %h", $time, exp_hsv.hue, hue);
            errors++;
          end
          if (saturation !== exp_hsv.sat) begin
            $display("%0t: saturation expected %h actual %h", $time, exp_hsv.sat, saturation);
            errors++;
          end
          if (brightness !== exp_hsv.val) begin
            $display("%0t: brightness expected %h actual %h", $time, exp_hsv.val, brightness);
            errors++;
          end
        end
        results_seen++;
        // long hold while the sender runs without gaps
        if (results_seen % 450 == 160) next_left = 80;
        else next_left = idle_cycles(results_seen);
      end else if (next_left > 0) begin
        next_left--;
      end
      stall_left = next_left;
      result_stall <= (next_left > 0);
    end
  end

  initial begin
    pixel_q.push_back(24'h000000);
    pixel_q.push_back(24'hFFFFFF);
    pixel_q.push_back(24'h808080);
    pixel_q.push_back(24'h010101);
    pixel_q.push_back(24'hFF0000);
    pixel_q.push_back(24'h00FF00);
    pixel_q.push_back(24'h0000FF);
    pixel_q.push_back(24'hFFFF00);
    pixel_q.push_back(24'h00FFFF);
    pixel_q.push_back(24'hFF00FF);
    pixel_q.push_back(24'hFFFFFE);
    pixel_q.push_back(24'hFEFFFF);
    pixel_q.push_back(24'hFF00FE);
    pixel_q.push_back(24'hFF0001);
    pixel_q.push_back(24'hFF0100);
    pixel_q.push_back(24'h010000);
    pixel_q.push_back(24'h000100);
    pixel_q.push_back(24'h000001);
    pixel_q.push_back(24'hFEFEFF);
    pixel_q.push_back(24'h7F7F80);
    pixel_q.push_back(24'h01FF00);
    pixel_q.push_back(24'hFF01FF);
    pixel_q.push_back(24'hAA55CC);
    for (int i = 0; i < NumRandom; i++) pixel_q.push_back(rand_pixel());
    n_pixels = pixel_q.size();
    repeat (2) @(posedge clk);
    rst <= 1'b0;
    while (pixels_sent < n_pixels || hsv_expected_q.size() != 0) @(posedge clk);
    repeat (30) @(posedge clk);
    if (errors == 0) $display("== PASS ==");
    else $display("== FAIL ==");
    $finish;
  end

  initial begin
    #5ms;
    $display("== FAIL ==");
    $finish;
  end

endmodule
